// ===== rtl/core/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types for the 3x3 fixed-point matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

  // Determinant status handed from the determinant stages to the divider
  typedef struct packed {
    logic neg;   // determinant is negative
    logic zero;  // determinant is exactly zero
  } det_flags_t;

  // Result flags, packed into tuser from the lowest bit up
  typedef struct packed {
    logic saturated;
    logic singular;
  } res_flags_t;

endpackage

// ===== rtl/core/matrix_inverse_3x3.sv =====
// Throughput: one matrix per cycle; the whole pipeline advances on one enable,
// held only while a finished result waits at the output register.
// Depth is set by the divider: one quotient bit per stage, WORD_BITS + 1 stages.
// Reset clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Fixed-point 3x3 inverse by adjugate over determinant, fully pipelined.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2; zero pad to bytes
  input  logic [((9*WORD_BITS+7)/8)*8-1:0]        s_axis_tdata_i,
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2; zero pad to bytes
  output logic [((9*WORD_BITS+7)/8)*8-1:0]        m_axis_tdata_o,
  // singular, saturated
  output mi3_pkg::res_flags_t                     m_axis_tuser_o,
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i
);

  import mi3_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int TW = ((9 * W + 7) / 8) * 8;

  // Global advance: every stage moves unless the output holds an untaken result
  logic en;

  logic signed [W-1:0]  ent [9];

  logic                 cof_vld;
  logic signed [2*W:0]  cof [9];
  logic signed [W-1:0]  row [3];

  logic                 det_vld;
  logic signed [2*W:0]  cof_d [9];
  logic [3*W-1:0]       den;
  det_flags_t           dflags;

  logic                 div_vld;
  logic [W:0]           quot [9];
  logic [8:0]           qneg;
  logic                 qzero;

  logic [TW-1:0]        tdata_d, tdata_q;
  res_flags_t           tuser_d, tuser_q;
  logic                 tvalid_q;

  assign en              = !tvalid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      ent[k] = $signed(s_axis_tdata_i[k*W +: W]);
    end
  end

  // Cofactors: products, then differences
  mi3_cof #(.W(W)) u_cof (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .ent_i   (ent),
    .valid_o (cof_vld),
    .cof_o   (cof),
    .row_o   (row)
  );

  // Determinant, its magnitude and sign; cofactors delayed to match
  mi3_det #(.W(W)) u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cof_vld),
    .cof_i   (cof),
    .row_i   (row),
    .valid_o (det_vld),
    .cof_o   (cof_d),
    .den_o   (den),
    .flags_o (dflags)
  );

  // Quotient magnitudes |cof| * 2^(2F) / |det|, W+1 bits so overflow shows
  mi3_div #(.W(W), .F(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (det_vld),
    .cof_i   (cof_d),
    .den_i   (den),
    .flags_i (dflags),
    .valid_o (div_vld),
    .quot_o  (quot),
    .neg_o   (qneg),
    .zero_o  (qzero)
  );

  // Sign restore and saturation. A negative result may reach exactly the
  // most negative word; a positive one stops one short of 2^(W-1).
  always_comb begin
    logic [W-1:0] v;
    logic         clip;
    logic         any_clip;
    tdata_d  = '0;
    any_clip = 1'b0;
    for (int l = 0; l < 9; l++) begin
      clip = quot[l][W] || (!qneg[l] && quot[l][W-1]) ||
             (qneg[l] && quot[l][W-1] && (quot[l][W-2:0] != '0));
      if (qzero) begin
        v = '0;
      end else if (clip) begin
        v = qneg[l] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        v = qneg[l] ? W'(-quot[l][W-1:0]) : quot[l][W-1:0];
      end
      any_clip = any_clip | (clip & !qzero);
      tdata_d[l*W +: W] = v;
    end
    tuser_d.singular  = qzero;
    tuser_d.saturated = any_clip;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else if (en) begin
      tvalid_q <= div_vld;
    end
  end

  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = tuser_q;
  assign m_axis_tvalid_o = tvalid_q;

endmodule

// ===== rtl/core/mi3_cof.sv =====
// ----------------------------------------------------------------------------
// mi3_cof
// Adjugate cofactors: 18 registered products, then 2x2 differences.
// ----------------------------------------------------------------------------
module mi3_cof #(
  parameter int W = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [W-1:0]   ent_i [9],
  output logic                  valid_o,
  output logic signed [2*W:0]   cof_o [9],
  output logic signed [W-1:0]   row_o [3]
);

  logic signed [2*W-1:0] pa_q [9];
  logic signed [2*W-1:0] pb_q [9];
  logic signed [2*W:0]   cof_q [9];
  logic signed [W-1:0]   row_a_q [3];
  logic signed [W-1:0]   row_b_q [3];
  logic [1:0]            vld_q;

  for (genvar k = 0; k < 9; k++) begin : g_cof
    localparam int R  = k / 3;
    localparam int C  = k % 3;
    localparam int R1 = (C + 1) % 3;
    localparam int R2 = (C + 2) % 3;
    localparam int C1 = (R + 1) % 3;
    localparam int C2 = (R + 2) % 3;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_q[k]  <= ent_i[R1*3+C1] * ent_i[R2*3+C2];
        pb_q[k]  <= ent_i[R1*3+C2] * ent_i[R2*3+C1];
        cof_q[k] <= (2*W+1)'(pa_q[k]) - (2*W+1)'(pb_q[k]);
      end
    end
  end

  // Row 0 rides alongside for the determinant expansion
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int t = 0; t < 3; t++) begin
        row_a_q[t] <= ent_i[t];
        row_b_q[t] <= row_a_q[t];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  assign valid_o = vld_q[1];
  assign cof_o   = cof_q;
  assign row_o   = row_b_q;

endmodule

// ===== rtl/core/mi3_det.sv =====
// ----------------------------------------------------------------------------
// mi3_det
// Determinant along row 0: split partial products, terms, sum, magnitude.
// ----------------------------------------------------------------------------
module mi3_det #(
  parameter int W = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [2*W:0]     cof_i [9],
  input  logic signed [W-1:0]     row_i [3],
  output logic                    valid_o,
  output logic signed [2*W:0]     cof_o [9],
  output logic [3*W-1:0]          den_o,
  output mi3_pkg::det_flags_t     flags_o
);

  import mi3_pkg::*;

  localparam int DETW = 3 * W + 1;
  localparam int DW   = 3 * W;

  logic signed [2*W:0]    pl_q [3];
  logic signed [2*W:0]    ph_q [3];
  logic signed [DETW-1:0] term_q [3];
  logic signed [DETW-1:0] det_q;
  logic [DW-1:0]          den_q;
  det_flags_t             flags_q;
  logic signed [2*W:0]    cd_q [4][9];
  logic [3:0]             vld_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int t = 0; t < 3; t++) begin
        // cofactor split into an unsigned low word and a signed high part
        pl_q[t]   <= row_i[t] * $signed({1'b0, cof_i[3*t][W-1:0]});
        ph_q[t]   <= row_i[t] * $signed(cof_i[3*t][2*W:W]);
        term_q[t] <= (DETW'(ph_q[t]) <<< W) + DETW'(pl_q[t]);
      end
      det_q         <= term_q[0] + term_q[1] + term_q[2];
      den_q         <= det_q[DETW-1] ? DW'(-det_q) : DW'(det_q);
      flags_q.neg   <= det_q[DETW-1];
      flags_q.zero  <= (det_q == '0);
      for (int k = 0; k < 9; k++) begin
        cd_q[0][k] <= cof_i[k];
        cd_q[1][k] <= cd_q[0][k];
        cd_q[2][k] <= cd_q[1][k];
        cd_q[3][k] <= cd_q[2][k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  assign valid_o = vld_q[3];
  assign cof_o   = cd_q[3];
  assign den_o   = den_q;
  assign flags_o = flags_q;

endmodule

// ===== rtl/core/mi3_div.sv =====
// ----------------------------------------------------------------------------
// mi3_div
// Nine restoring dividers, one quotient bit per stage, shared divisor line.
// ----------------------------------------------------------------------------
module mi3_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [2*W:0]   cof_i [9],
  input  logic [3*W-1:0]        den_i,
  input  mi3_pkg::det_flags_t   flags_i,
  output logic                  valid_o,
  output logic [W:0]            quot_o [9],
  output logic [8:0]            neg_o,
  output logic                  zero_o
);

  import mi3_pkg::*;

  localparam int NW = 2 * W + 2 * F;  // shifted numerator magnitude
  localparam int DW = 3 * W;          // divisor magnitude
  localparam int CW = 4 * W;          // divisor shifted by up to W
  localparam int NS = W + 2;          // load stage plus W+1 bit stages

  logic [NW-1:0]  rem_q [NS][9];
  logic [W:0]     qt_q  [NS][9];
  logic [DW-1:0]  den_q [NS];
  logic [8:0]     neg_q [NS];
  logic [NS-1:0]  zero_q;
  logic [NS-1:0]  vld_q;
  logic [2*W:0]   mag [9];

  always_comb begin
    for (int l = 0; l < 9; l++) begin
      mag[l] = cof_i[l][2*W] ? (2*W+1)'(-cof_i[l]) : cof_i[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 9; l++) begin
        rem_q[0][l] <= NW'(mag[l]) << (2 * F);
        qt_q[0][l]  <= '0;
        neg_q[0][l] <= cof_i[l][2*W] ^ flags_i.neg;
      end
      den_q[0]  <= den_i;
      zero_q[0] <= flags_i.zero;
    end
  end

  // stage s decides quotient bit W-s; bits shift in MSB first
  for (genvar s = 0; s < NS - 1; s++) begin : g_stage
    for (genvar l = 0; l < 9; l++) begin : g_lane
      logic [CW:0] diff;
      logic        ge;

      assign diff = {1'b0, CW'(rem_q[s][l])} - {1'b0, CW'(den_q[s]) << (W - s)};
      assign ge   = !diff[CW];

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s+1][l] <= ge ? diff[NW-1:0] : rem_q[s][l];
          qt_q[s+1][l]  <= {qt_q[s][l][W-1:0], ge};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s+1]  <= den_q[s];
        neg_q[s+1]  <= neg_q[s];
        zero_q[s+1] <= zero_q[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quot_o  = qt_q[NS-1];
  assign neg_o   = neg_q[NS-1];
  assign zero_o  = zero_q[NS-1];

endmodule
